FILE: rtl/cpr_pkg.sv
`timescale 1ns / 1ps
// Shared types, keyword table and result codes for the command prefix recognizer.
// No dependencies; the files that use it refer to this package by scoped names.
package cpr_pkg;

  localparam int NUM_KW    = 30;
  localparam int KW_MAXLEN = 14;
  localparam int MASK_BITS = NUM_KW + 1;

  localparam logic [4:0] KIND_NONE      = 5'd0;
  localparam logic [4:0] KIND_AP        = 5'd1;
  localparam logic [4:0] KIND_RULE_BASE = 5'd2;

  localparam logic [MASK_BITS-1:0] MASK_ALL = '1;

  localparam logic [7:0] CHR_A     = 8'h61;
  localparam logic [7:0] CHR_P     = 8'h70;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;

  // Keyword text, right aligned: the last character sits in the low byte.
  localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [NUM_KW] = '{
    "?", "ls", "mkdir", "rm", "mv", "ftype", "md5sum",
    "config-restore", "config-default", "config-get", "config-set",
    "time", "M482", "M483", "wlan", "M942", "M951", "M952",
    "sn-get", "sn-set", "sys-time", "clearftm", "upgrade", "reset",
    "diagnose", "wifi-diag", "mock-sd", "mock-nvs", "mock-net", "version"
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd1, 4'd2, 4'd5, 4'd2, 4'd2, 4'd5, 4'd6, 4'd14, 4'd14, 4'd10, 4'd10,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd8, 4'd8,
    4'd7, 4'd5, 4'd8, 4'd9, 4'd7, 4'd8, 4'd8, 4'd7
  };

  localparam logic [3:0] KW_ARG [NUM_KW] = '{
    4'd0, 4'd2, 4'd5, 4'd2, 4'd2, 4'd0, 4'd7, 4'd15, 4'd15, 4'd11, 4'd11,
    4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd7, 4'd8, 4'd8, 4'd0
  };

  localparam logic KW_NOLIMIT [NUM_KW] = '{
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
  };

  typedef struct packed {
    logic [MASK_BITS-1:0] mask;
    logic                 third_is_space;
  } cpr_state_t;

  typedef struct packed {
    logic [4:0]  command_kind;
    logic [15:0] argument_offset;
    logic        within_limit;
  } cpr_result_t;

endpackage

FILE: rtl/cpr_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for payload bytes and recognition results.
// No dependencies.
interface cpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_payload;

  modport source (output valid, data_byte, last_byte, empty_payload, input ready);
  modport sink   (input valid, data_byte, last_byte, empty_payload, output ready);
endinterface

interface cpr_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  command_kind;
  logic [15:0] argument_offset;
  logic        within_limit;

  modport source (output valid, command_kind, argument_offset, within_limit, input ready);
  modport sink   (input valid, command_kind, argument_offset, within_limit, output ready);
endinterface

FILE: rtl/cpr_step.sv
`timescale 1ns / 1ps
// Per-byte update: clears live bits of the ap form and keywords that disagree, advances the count.
// Depends on cpr_pkg.
module cpr_step #(
  parameter int COUNT_BITS = 16
) (
  input  cpr_pkg::cpr_state_t    state,
  input  logic [COUNT_BITS-1:0]  count,
  input  logic [7:0]             data_byte,
  output cpr_pkg::cpr_state_t    state_next,
  output logic [COUNT_BITS-1:0]  count_next
);

  logic       pos_in_table;
  logic [3:0] pos4;
  logic       is_ws;
  logic [3:0] idx;
  logic [7:0] kw_chr;

  assign pos_in_table = (32'(count) < 32'(cpr_pkg::KW_MAXLEN));
  assign pos4         = count[3:0];
  assign is_ws = (data_byte == cpr_pkg::CHR_SPACE) ||
                 ((data_byte >= cpr_pkg::CHR_TAB) && (data_byte <= cpr_pkg::CHR_CR));

  always_comb begin
    state_next = state;
    idx        = '0;
    kw_chr     = '0;
    if ((count == COUNT_BITS'(0)) && (data_byte != cpr_pkg::CHR_A)) begin
      state_next.mask[0] = 1'b0;
    end
    if ((count == COUNT_BITS'(1)) && (data_byte != cpr_pkg::CHR_P)) begin
      state_next.mask[0] = 1'b0;
    end
    if (count == COUNT_BITS'(2)) begin
      if (!((data_byte == cpr_pkg::CHR_NUL) || is_ws)) begin
        state_next.mask[0] = 1'b0;
      end
      state_next.third_is_space = (data_byte == cpr_pkg::CHR_SPACE);
    end
    for (int k = 0; k < cpr_pkg::NUM_KW; k++) begin
      idx    = cpr_pkg::KW_LEN[k] - 4'd1 - pos4;
      kw_chr = cpr_pkg::KW_TEXT[k][{idx, 3'b000} +: 8];
      if (pos_in_table && (pos4 < cpr_pkg::KW_LEN[k]) && (data_byte != kw_chr)) begin
        state_next.mask[k+1] = 1'b0;
      end
    end
  end

  // Saturate at all ones.
  assign count_next = (&count) ? count : count + COUNT_BITS'(1);

endmodule

FILE: rtl/cpr_resolve.sv
`timescale 1ns / 1ps
// End-of-payload decision: the ap form if live, else the first live keyword that fits; its offset and limit flag.
// Depends on cpr_pkg.
module cpr_resolve #(
  parameter int COUNT_BITS   = 16,
  parameter int LENGTH_LIMIT = 128
) (
  input  cpr_pkg::cpr_state_t   state,
  input  logic [COUNT_BITS-1:0] length,
  output cpr_pkg::cpr_result_t  result
);

  logic [31:0]                n_ext;
  logic [15:0]                n_cap;
  logic                       len_ok;
  logic [cpr_pkg::NUM_KW-1:0] hit;
  logic [4:0]                 sel;

  assign n_ext  = 32'(length);
  assign n_cap  = (n_ext > 32'hFFFF) ? 16'hFFFF : n_ext[15:0];
  assign len_ok = !(&length) && (n_ext <= 32'(LENGTH_LIMIT));

  always_comb begin
    sel = '0;
    for (int k = 0; k < cpr_pkg::NUM_KW; k++) begin
      hit[k] = state.mask[k+1] && (n_ext >= 32'(cpr_pkg::KW_LEN[k]));
    end
    // Lowest index wins.
    for (int k = cpr_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (hit[k]) begin
        sel = 5'(k);
      end
    end
  end

  always_comb begin
    result = '{command_kind: cpr_pkg::KIND_NONE, argument_offset: '0, within_limit: 1'b0};
    if (state.mask[0] && (n_ext >= 32'd3)) begin
      result.command_kind    = cpr_pkg::KIND_AP;
      result.argument_offset = state.third_is_space ? 16'd3 : n_cap;
      result.within_limit    = len_ok;
    end else if (|hit) begin
      result.command_kind    = cpr_pkg::KIND_RULE_BASE + sel;
      result.argument_offset = (n_ext > 32'(cpr_pkg::KW_ARG[sel])) ?
                               16'(cpr_pkg::KW_ARG[sel]) : n_cap;
      result.within_limit    = cpr_pkg::KW_NOLIMIT[sel] || len_ok;
    end
  end

endmodule

FILE: rtl/command_prefix_recognizer_unit.sv
`timescale 1ns / 1ps
// Top level of the command prefix recognizer: input register, state, result register.
// Depends on cpr_pkg, cpr_if (cpr_in_if, cpr_out_if), cpr_step and cpr_resolve.
//
//  port | dir | carries
//  -----+-----+---------------------------------------------------------
//  cmd  | in  | data_byte, last_byte, empty_payload (one payload byte)
//  res  | out | command_kind, argument_offset, within_limit (per payload)
//
// One item per cycle sustained while no result stall holds it back. An item is held in the
// input register; its result, if any, is loaded into the result register when that item
// proceeds. The per-byte keyword compare and end-of-payload priority pick are combinational.
// rst clears the input and result valid bits and returns the recognizer state.
// A stalled result blocks only the item that ends the next payload (final byte or empty
// payload); earlier bytes flow.
module command_prefix_recognizer_unit #(
  parameter int LENGTH_LIMIT = 128,
  parameter int COUNT_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  cpr_in_if.sink           cmd,
  cpr_out_if.source        res
);

  logic                  in_vld;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  in_empty;
  logic                  ends;
  logic                  proceed;

  cpr_pkg::cpr_state_t   state;
  cpr_pkg::cpr_state_t   state_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] length;
  cpr_pkg::cpr_result_t  result;

  logic                  res_vld;
  cpr_pkg::cpr_result_t  res_data;

  assign ends    = in_last || in_empty;
  assign proceed = in_vld && (!ends || !res_vld || res.ready);
  assign cmd.ready = !in_vld || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (cmd.ready) begin
      in_vld <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_byte  <= cmd.data_byte;
      in_last  <= cmd.last_byte;
      in_empty <= cmd.empty_payload;
    end
  end

  cpr_step #(.COUNT_BITS(COUNT_BITS)) u_step (
    .state      (state),
    .count      (count),
    .data_byte  (in_byte),
    .state_next (state_next),
    .count_next (count_next)
  );

  // An empty payload has length zero whatever the state holds.
  assign length = in_empty ? '0 : count_next;

  cpr_resolve #(.COUNT_BITS(COUNT_BITS), .LENGTH_LIMIT(LENGTH_LIMIT)) u_resolve (
    .state  (state_next),
    .length (length),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mask: cpr_pkg::MASK_ALL, third_is_space: 1'b0};
      count <= '0;
    end else if (proceed) begin
      if (ends) begin
        state <= '{mask: cpr_pkg::MASK_ALL, third_is_space: 1'b0};
        count <= '0;
      end else begin
        state <= state_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (proceed && ends) begin
      res_vld <= 1'b1;
    end else if (res.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && ends) begin
      res_data <= result;
    end
  end

  assign res.valid           = res_vld;
  assign res.command_kind    = res_data.command_kind;
  assign res.argument_offset = res_data.argument_offset;
  assign res.within_limit    = res_data.within_limit;

`ifndef SYNTHESIS
  a_end_resets_state: assert property (@(posedge clk) disable iff (rst)
    (proceed && ends) |=> (count == '0) && (state.mask == cpr_pkg::MASK_ALL))
    else $error("state not returned to reset after payload end");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (proceed && ends) |=> res.valid)
    else $error("payload end produced no result");

  a_no_match_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.command_kind == cpr_pkg::KIND_NONE)) |->
      ((res.argument_offset == 16'd0) && !res.within_limit))
    else $error("no-match result carries offset or limit flag");

  a_ap_offset: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.command_kind == cpr_pkg::KIND_AP)) |->
      (res.argument_offset >= 16'd3))
    else $error("access point offset below three");
`endif

endmodule

FILE: sim/tb_command_prefix_recognizer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_prefix_recognizer_unit: a directed table of payloads,
// then random keyword-shaped payloads, scored against typed-in results or a built-in keyword predictor.
// Depends on cpr_pkg and cpr_if (cpr_in_if, cpr_out_if).
module tb_command_prefix_recognizer_unit;

  localparam int LENGTH_LIMIT = 128;
  localparam int COUNT_BITS   = 16;
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  localparam logic [4:0] RULE0 = cpr_pkg::KIND_RULE_BASE;

  typedef enum int {
    KW_QUERY, KW_LS, KW_MKDIR, KW_RM, KW_MV, KW_FTYPE, KW_MD5SUM,
    KW_CFG_RESTORE, KW_CFG_DEFAULT, KW_CFG_GET, KW_CFG_SET, KW_TIME,
    KW_M482, KW_M483, KW_WLAN, KW_M942, KW_M951, KW_M952, KW_SN_GET, KW_SN_SET,
    KW_SYS_TIME, KW_CLEARFTM, KW_UPGRADE, KW_RESET, KW_DIAGNOSE, KW_WIFI_DIAG,
    KW_MOCK_SD, KW_MOCK_NVS, KW_MOCK_NET, KW_VERSION, KW_COUNT
  } keyword_e;

  typedef logic [7:0] byte_q_t [$];

  typedef struct {
    string                text;   // '#' stands for a NUL byte
    int                   fill;   // 'x' bytes appended after text
    bit                   empty;
    bit                   known;  // result typed in below, not predicted
    cpr_pkg::cpr_result_t want;
  } payload_row_t;

  string keyword_text [KW_COUNT] = '{
    "?", "ls", "mkdir", "rm", "mv", "ftype", "md5sum",
    "config-restore", "config-default", "config-get", "config-set",
    "time", "M482", "M483", "wlan", "M942", "M951", "M952", "sn-get", "sn-set",
    "sys-time", "clearftm", "upgrade", "reset", "diagnose", "wifi-diag",
    "mock-sd", "mock-nvs", "mock-net", "version"
  };
  int keyword_arg_at [KW_COUNT] = '{
    0, 2, 5, 2, 2, 0, 7, 15, 15, 11, 11, 4, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 7, 8, 8, 0
  };
  bit keyword_unlimited [KW_COUNT] = '{
    1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0,
    0, 0, 1, 1, 1, 1, 0, 0, 0, 1
  };
  logic [7:0] blank_bytes [7] = '{8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

  payload_row_t plan [23] = '{
    '{"",                 0,     1, 1, '{cpr_pkg::KIND_NONE, 16'd0, 1'b0}},
    '{"?",                0,     0, 1, '{RULE0 + 5'(KW_QUERY), 16'd0, 1'b1}},
    '{"ls",               0,     0, 1, '{RULE0 + 5'(KW_LS), 16'd2, 1'b1}},
    '{"ap",               0,     0, 1, '{cpr_pkg::KIND_NONE, 16'd0, 1'b0}},
    '{"ap ",              0,     0, 1, '{cpr_pkg::KIND_AP, 16'd3, 1'b1}},
    '{"ap\t",             5,     0, 1, '{cpr_pkg::KIND_AP, 16'd8, 1'b1}},
    '{"ap#",              0,     0, 1, '{cpr_pkg::KIND_AP, 16'd3, 1'b1}},
    '{"apx",              0,     0, 1, '{cpr_pkg::KIND_NONE, 16'd0, 1'b0}},
    '{"config-restore",   0,     0, 1, '{RULE0 + 5'(KW_CFG_RESTORE), 16'd14, 1'b1}},
    '{"config-restore x", 0,     0, 1, '{RULE0 + 5'(KW_CFG_RESTORE), 16'd15, 1'b1}},
    '{"md5sum",           0,     0, 1, '{RULE0 + 5'(KW_MD5SUM), 16'd6, 1'b1}},
    '{"ls",               126,   0, 1, '{RULE0 + 5'(KW_LS), 16'd2, 1'b1}},
    '{"ls",               127,   0, 1, '{RULE0 + 5'(KW_LS), 16'd2, 1'b0}},
    '{"version",          122,   0, 1, '{RULE0 + 5'(KW_VERSION), 16'd0, 1'b1}},
    '{"\377",             0,     0, 1, '{cpr_pkg::KIND_NONE, 16'd0, 1'b0}},
    '{"mock-net",         0,     0, 1, '{RULE0 + 5'(KW_MOCK_NET), 16'd8, 1'b1}},
    '{"M951 x",           0,     0, 1, '{RULE0 + 5'(KW_M951), 16'd0, 1'b1}},
    '{"mkdi",             0,     0, 1, '{cpr_pkg::KIND_NONE, 16'd0, 1'b0}},
    '{"sys-time",         0,     0, 0, '{cpr_pkg::KIND_NONE, 16'd0, 1'b0}},
    '{"wifi-diag q",      0,     0, 0, '{cpr_pkg::KIND_NONE, 16'd0, 1'b0}},
    '{"ap\n",             2,     0, 1, '{cpr_pkg::KIND_AP, 16'd5, 1'b1}},
    '{"time x",           0,     0, 1, '{RULE0 + 5'(KW_TIME), 16'd4, 1'b1}},
    '{"?",                3,     0, 1, '{RULE0 + 5'(KW_QUERY), 16'd0, 1'b1}}
  };

  logic clk;
  logic rst;

  cpr_in_if  cmd_ch ();
  cpr_out_if res_ch ();

  command_prefix_recognizer_unit #(
    .LENGTH_LIMIT (LENGTH_LIMIT),
    .COUNT_BITS   (COUNT_BITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Predictor state for the payload in flight
  logic [30:0] alive_keywords;
  int          bytes_seen;
  bit          third_space;

  cpr_pkg::cpr_result_t pending_results [$];
  int accepted_items;
  int results_checked;
  int mismatch_count;
  int quiet_cycles;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_payload_state();
    alive_keywords = '1;
    bytes_seen     = 0;
    third_space    = 1'b0;
  endfunction

  function automatic logic [15:0] clamp16(input int n);
    return (n > 65535) ? 16'hFFFF : 16'(n);
  endfunction

  function automatic bit length_fits(input int n);
    return (n < COUNT_MAX) && (n <= LENGTH_LIMIT);
  endfunction

  // Advance the keyword trackers by one item; return 1 when a payload ends.
  function automatic bit predict_command(input logic [7:0] b, input bit last, input bit empty,
                                         output cpr_pkg::cpr_result_t r);
    int  n;
    int  k;
    int  arg;
    bit  found;
    r = '{cpr_pkg::KIND_NONE, 16'd0, 1'b0};
    if (!empty) begin
      if (bytes_seen == 0 && b != cpr_pkg::CHR_A) alive_keywords[0] = 1'b0;
      if (bytes_seen == 1 && b != cpr_pkg::CHR_P) alive_keywords[0] = 1'b0;
      if (bytes_seen == 2) begin
        if (!(b == 8'h00 || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)))
          alive_keywords[0] = 1'b0;
        third_space = (b == cpr_pkg::CHR_SPACE);
      end
      for (k = 0; k < KW_COUNT; k++) begin
        if (bytes_seen < keyword_text[k].len() && b != 8'(keyword_text[k][bytes_seen]))
          alive_keywords[k+1] = 1'b0;
      end
      if (bytes_seen < COUNT_MAX) bytes_seen++;
      if (!last) return 1'b0;
    end
    n = empty ? 0 : bytes_seen;
    if (n >= 3 && alive_keywords[0]) begin
      r.command_kind    = cpr_pkg::KIND_AP;
      r.argument_offset = third_space ? 16'd3 : clamp16(n);
      r.within_limit    = length_fits(n);
    end else begin
      found = 1'b0;
      for (k = 0; k < KW_COUNT; k++) begin
        if (!found && alive_keywords[k+1] && n >= keyword_text[k].len()) begin
          found = 1'b1;
          arg = keyword_arg_at[k];
          r.command_kind    = RULE0 + 5'(k);
          r.argument_offset = clamp16(n > arg ? arg : n);
          r.within_limit    = keyword_unlimited[k] || length_fits(n);
        end
      end
    end
    clear_payload_state();
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last, input bit empty,
                           input bit typed, input cpr_pkg::cpr_result_t want);
    cpr_pkg::cpr_result_t predicted;
    while (!calm && $urandom_range(99) < 37) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.data_byte     <= b;
    cmd_ch.last_byte     <= last;
    cmd_ch.empty_payload <= empty;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    accepted_items++;
    if (predict_command(b, last, empty, predicted))
      pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  task automatic send_payload(input byte_q_t body, input bit typed,
                              input cpr_pkg::cpr_result_t want);
    foreach (body[i]) send_byte(body[i], i == body.size() - 1, 1'b0, typed, want);
  endtask

  initial begin : stimulus
    byte_q_t body;
    int      i;
    int      pick;
    int      kw;
    int      tail;
    int      payloads;
    int      random_start;
    cpr_pkg::cpr_result_t none;
    none = '{cpr_pkg::KIND_NONE, 16'd0, 1'b0};
    calm = 1'b0;
    accepted_items  = 0;
    clear_payload_state();
    rst                  <= 1'b1;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.data_byte     <= 8'h00;
    cmd_ch.last_byte     <= 1'b0;
    cmd_ch.empty_payload <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      body.delete();
      if (plan[r].empty) begin
        send_byte(8'($urandom), 1'($urandom), 1'b1, plan[r].known, plan[r].want);
      end else begin
        for (i = 0; i < plan[r].text.len(); i++)
          body.insert(body.size(), plan[r].text[i] == "#" ? 8'h00 : 8'(plan[r].text[i]));
        repeat (plan[r].fill) body.insert(body.size(), "x");
        send_payload(body, plan[r].known, plan[r].want);
      end
    end

    // First pass walks the ap form and every keyword in order, then pick at random.
    payloads = 0;
    random_start = accepted_items;
    while (accepted_items - random_start < RANDOM_ITEMS) begin
      calm = (payloads >= 8 && payloads < 24);
      body.delete();
      pick = (payloads <= KW_COUNT) ? 0 : $urandom_range(99);
      kw   = (payloads <= KW_COUNT) ? payloads : $urandom_range(KW_COUNT);
      if (pick < 80) begin
        if (kw == 0) begin
          body.insert(body.size(), cpr_pkg::CHR_A);
          body.insert(body.size(), cpr_pkg::CHR_P);
          body.insert(body.size(), blank_bytes[$urandom_range(6)]);
        end else begin
          for (i = 0; i < keyword_text[kw-1].len(); i++)
            body.insert(body.size(), 8'(keyword_text[kw-1][i]));
        end
        if (pick >= 65) begin
          // break the keyword: corrupt one byte or cut the end off
          if ($urandom_range(1)) body[$urandom_range(body.size() - 1)] = 8'($urandom);
          else body.delete(body.size() - 1);
        end
        tail = ($urandom_range(19) == 0) ? $urandom_range(135, 115) : $urandom_range(8);
        repeat (tail)
          body.insert(body.size(),
                      ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(126, 32)));
        if (body.size() == 0) body.insert(body.size(), 8'($urandom));
        send_payload(body, 1'b0, none);
      end else if (pick < 90) begin
        repeat ($urandom_range(16, 1)) body.insert(body.size(), 8'($urandom));
        send_payload(body, 1'b0, none);
      end else begin
        // empty payload, sometimes cutting short a payload already under way
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0, 1'b0, 1'b0, none);
        send_byte(8'($urandom), 1'($urandom), 1'b1, 1'b0, none);
      end
      payloads++;
    end
    calm = 1'b0;
    cmd_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d payloads in %0d items: every keyword, the ap form, empty and cut-off",
             payloads + $size(plan), accepted_items);
    $display("payloads, length-limit edges and a long result stall; %0d results checked",
             results_checked);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    bit hold_done;
    cpr_pkg::cpr_result_t got;
    cpr_pkg::cpr_result_t want;
    hold_left = 0;
    hold_done = 1'b0;
    results_checked = 0;
    mismatch_count  = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.command_kind, res_ch.argument_offset, res_ch.within_limit};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: result with nothing expected: kind %0d offset %0d limit %0b",
                     $realtime, got.command_kind, got.argument_offset, got.within_limit);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.command_kind !== want.command_kind ||
              got.argument_offset !== want.argument_offset ||
              got.within_limit !== want.within_limit) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("%0t: result %0d: expected kind %0d offset %0d limit %0b, got %0d %0d %0b",
                       $realtime, results_checked, want.command_kind, want.argument_offset,
                       want.within_limit, got.command_kind, got.argument_offset,
                       got.within_limit);
          end
        end
      end
      // hold off once for a long stretch so the input side backs up
      if (!hold_done && results_checked == 32) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
